[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros for the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MLK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define MLK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/mlk_pkg.sv]
// ----------------------------------------------------------------------------
// mlk_pkg
// types, constants and the letter table of the morse letter keyer
// ----------------------------------------------------------------------------
package mlk_pkg;

  localparam int DOT_W = 8;
  localparam int DUR_W = 11;

  localparam logic [DOT_W-1:0] DOT_MIN   = 8'd20;
  localparam logic [DOT_W-1:0] DOT_MAX   = 8'd200;
  localparam logic [DOT_W-1:0] DOT_RESET = 8'd100;

  localparam logic [7:0] CH_FOLD  = 8'h60;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LO    = 8'h40;
  localparam logic [7:0] CH_HI    = 8'h5B;
  localparam logic [7:0] CH_A     = 8'h41;

  localparam logic [1:0] ELEM_NONE = 2'd0;
  localparam logic [1:0] ELEM_DOT  = 2'd1;
  localparam logic [1:0] ELEM_TWO  = 2'd2;
  localparam logic [1:0] ELEM_DASH = 2'd3;

  typedef struct packed {
    logic             key_on;
    logic [DUR_W-1:0] duration;
    logic             last_segment;
  } seg_t;

  // four 2-bit element codes per letter, first element in bits 7..6
  function automatic logic [7:0] letter_code(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:    c = 8'h70;
      5'd1:    c = 8'hD5;
      5'd2:    c = 8'hDD;
      5'd3:    c = 8'hD4;
      5'd4:    c = 8'h40;
      5'd5:    c = 8'h5D;
      5'd6:    c = 8'hF4;
      5'd7:    c = 8'h55;
      5'd8:    c = 8'h50;
      5'd9:    c = 8'h7F;
      5'd10:   c = 8'hDC;
      5'd11:   c = 8'h75;
      5'd12:   c = 8'hF0;
      5'd13:   c = 8'hD0;
      5'd14:   c = 8'hFC;
      5'd15:   c = 8'h7D;
      5'd16:   c = 8'hF7;
      5'd17:   c = 8'h74;
      5'd18:   c = 8'h54;
      5'd19:   c = 8'hC0;
      5'd20:   c = 8'h5C;
      5'd21:   c = 8'h57;
      5'd22:   c = 8'h7C;
      5'd23:   c = 8'hD7;
      5'd24:   c = 8'hDF;
      5'd25:   c = 8'hF5;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // move the non-empty elements to the top, so a zero pair marks the end
  function automatic logic [7:0] compact_code(input logic [7:0] c);
    logic [7:0] r;
    int         n;
    r = '0;
    n = 0;
    for (int k = 3; k >= 0; k--) begin
      if (c[2*k +: 2] != ELEM_NONE) begin
        r[2*(3-n) +: 2] = c[2*k +: 2];
        n = n + 1;
      end
    end
    return r;
  endfunction

endpackage

[src/mlk_ifs.sv]
// ----------------------------------------------------------------------------
// mlk_ifs
// valid/ready channels of the morse letter keyer
// ----------------------------------------------------------------------------
interface mlk_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] dot_length;
  modport source (output valid, output dot_length, input ready);
  modport sink (input valid, input dot_length, output ready);
endinterface

interface mlk_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface mlk_seg_if;
  logic        valid;
  logic        ready;
  logic        key_on;
  logic [10:0] duration;
  logic        last_segment;
  modport source (output valid, output key_on, output duration, output last_segment,
                  input ready);
  modport sink (input valid, input key_on, input duration, input last_segment,
                output ready);
endinterface

[src/morse_letter_keyer_top.sv]
// ----------------------------------------------------------------------------
// morse_letter_keyer_top
// turns message bytes into timed morse key segments
// ----------------------------------------------------------------------------
// channels: cfg writes the dot length (saturated to 20..200, reset 100) and is
// always ready; write it only while no character is in flight. char_in takes
// one message byte per beat; seg_out gives one key segment per beat, with
// last_segment set on the final segment of a character.
// a space gives one segment, a letter 2 * elements + 1 (at most nine), any
// other byte none.
// a character's first segment passes the generator state and then the output
// register. segments follow one per cycle while seg_out is ready, so a letter
// occupies the segment generator for its 3 to 9 segments, and the next
// character is taken in the cycle that its predecessor's last segment moves
// into the output register; a byte with no segments leaves the generator idle.
// a stall on seg_out holds the output register and the generator; char_in
// drops ready until the current character's last segment has moved on.
// reset (synchronous) empties the generator and output register and sets the
// dot length back to 100.
// ----------------------------------------------------------------------------
module morse_letter_keyer_top
  import mlk_pkg::*;
(
  input logic        clk,
  input logic        rst,
  mlk_cfg_if.sink    cfg,
  mlk_char_if.sink   char_in,
  mlk_seg_if.source  seg_out
);

  logic [DOT_W-1:0] dot;
  logic [DOT_W-1:0] dot_sat;

  // segment generator state
  logic       busy;
  logic       space;
  logic       off_phase;
  logic [7:0] rem;

  // decode of the incoming byte
  logic [7:0] ch_fold;
  logic [7:0] ch_ofs;
  logic       dec_space;
  logic       dec_letter;
  logic [7:0] dec_code;

  logic [DUR_W-1:0] dot1;
  logic [DUR_W-1:0] dot3;
  logic [DUR_W-1:0] dot7;
  logic [DUR_W-1:0] elem_dur;
  seg_t             seg_cur;
  seg_t             seg_q;
  logic             out_valid;
  logic             advance;
  logic             accept;

  assign cfg.ready = 1'b1;

  always_comb begin
    priority if (cfg.dot_length < DOT_MIN) begin
      dot_sat = DOT_MIN;
    end else if (cfg.dot_length > DOT_MAX) begin
      dot_sat = DOT_MAX;
    end else begin
      dot_sat = cfg.dot_length;
    end
  end

  always_comb begin
    ch_fold    = (char_in.character > CH_FOLD) ? char_in.character - CASE_OFS
                                               : char_in.character;
    ch_ofs     = ch_fold - CH_A;
    dec_space  = (ch_fold == CH_SPACE);
    dec_letter = (ch_fold > CH_LO) && (ch_fold < CH_HI);
    dec_code   = compact_code(letter_code(ch_ofs[4:0]));
  end

  always_comb begin
    dot1 = {{(DUR_W-DOT_W){1'b0}}, dot};
    dot3 = dot1 + (dot1 << 1);
    dot7 = (dot1 << 3) - dot1;
    unique case (rem[7:6])
      ELEM_DOT:  elem_dur = dot1;
      ELEM_TWO:  elem_dur = dot1 << 1;
      ELEM_DASH: elem_dur = dot3;
      default:   elem_dur = dot3;
    endcase
  end

  always_comb begin
    priority if (space) begin
      seg_cur = '{key_on: 1'b0, duration: dot7, last_segment: 1'b1};
    end else if (off_phase) begin
      seg_cur = '{key_on: 1'b0, duration: dot1, last_segment: 1'b0};
    end else if (rem[7:6] != ELEM_NONE) begin
      seg_cur = '{key_on: 1'b1, duration: elem_dur, last_segment: 1'b0};
    end else begin
      // letter gap closes the character
      seg_cur = '{key_on: 1'b0, duration: dot3, last_segment: 1'b1};
    end
  end

  assign advance       = busy && (!out_valid || seg_out.ready);
  assign char_in.ready = !busy || (advance && seg_cur.last_segment);
  assign accept        = char_in.valid && char_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot       <= DOT_RESET;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        dot <= dot_sat;
      end
      if (accept) begin
        busy <= dec_space || dec_letter;
      end else if (advance && seg_cur.last_segment) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (seg_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      space     <= dec_space;
      rem       <= dec_code;
      off_phase <= 1'b0;
    end else if (advance) begin
      if (off_phase) begin
        rem <= rem << 2;
      end
      off_phase <= !off_phase && !space && (rem[7:6] != ELEM_NONE);
    end
    if (advance) begin
      seg_q <= seg_cur;
    end
  end

  assign seg_out.valid        = out_valid;
  assign seg_out.key_on       = seg_q.key_on;
  assign seg_out.duration     = seg_q.duration;
  assign seg_out.last_segment = seg_q.last_segment;

endmodule

[src/mlk_checker.sv]
// ----------------------------------------------------------------------------
// mlk_checker
// port-level checks of the morse letter keyer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlk_checker (
  input logic        clk,
  input logic        rst,
  input logic        seg_valid,
  input logic        seg_ready,
  input logic        key_on,
  input logic [10:0] duration,
  input logic        last_segment
);

  // a stalled beat stays on the port unchanged
  `MLK_ASSERT_NXT(a_seg_hold, clk, rst, seg_valid && !seg_ready, seg_valid)
  `MLK_ASSERT_NXT(a_seg_stable, clk, rst, seg_valid && !seg_ready,
    $stable(key_on) && $stable(duration) && $stable(last_segment))

  // every segment is a whole number of dots, at least one, at most seven max dots
  `MLK_ASSERT_IMP(a_dur_range, clk, rst, seg_valid,
    duration >= 11'd20 && duration <= 11'd1400)

  // a character always closes with a gap, never a keyed element
  `MLK_ASSERT_IMP(a_last_off, clk, rst, seg_valid && key_on, !last_segment)

endmodule

bind morse_letter_keyer_top mlk_checker u_mlk_checker (
  .clk          (clk),
  .rst          (rst),
  .seg_valid    (seg_out.valid),
  .seg_ready    (seg_out.ready),
  .key_on       (seg_out.key_on),
  .duration     (seg_out.duration),
  .last_segment (seg_out.last_segment)
);
